[src/gwwb_pkg.sv]
// Shared constants, types and the wrap width function of the word-wrap line breaker.
`default_nettype none

package gwwb_pkg;

    localparam int POS_W   = 16;   // source line position counters
    localparam int COLS_W  = 10;   // screen column register
    localparam int OFF_W   = 16;   // line_offset field
    localparam int LEN_W   = 11;   // line_length field
    localparam int IDX_W   = 16;   // display_index field
    localparam int CH_W    = 8;
    localparam int CMP_W   = (POS_W > COLS_W) ? POS_W : COLS_W;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;

    localparam int OUT_DATA_W = ((IDX_W + OFF_W + LEN_W + 7) / 8) * 8;

    localparam logic [CH_W-1:0]   CH_SPACE   = 8'd32;
    localparam logic [CH_W-1:0]   CH_HYPHEN  = 8'd45;
    localparam logic [COLS_W-1:0] COLS_RESET = COLS_W'(80);
    localparam logic [POS_W-1:0]  POS_MAX    = {POS_W{1'b1}};
    localparam logic [IDX_W-1:0]  IDX_MAX    = {IDX_W{1'b1}};

    // floor(2c/25) by reciprocal; the shift is wide enough that no correction is needed
    localparam int     DIV_SH    = COLS_W + 6;
    localparam longint DIV_RECIP = ((64'sd1 <<< DIV_SH) + 64'sd24) / 64'sd25;

    // One queued request: the break line (or lone tail line) and an optional tail line
    typedef struct packed {
        logic             two;
        logic [OFF_W-1:0] a_off;
        logic [LEN_W-1:0] a_len;
        logic             a_end;
        logic [OFF_W-1:0] b_off;
        logic [LEN_W-1:0] b_len;
        logic             too_long;
    } gwwb_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } gwwb_qstat_t;

    // Wrap width: cols - 2*floor(cols*8/100), at least one
    function automatic logic [COLS_W-1:0] wrap_width_f(input logic [COLS_W-1:0] cols);
        logic [COLS_W:0]   x;
        logic [63:0]       prod;
        logic [COLS_W-1:0] marg;
        logic [COLS_W-1:0] w;
        x    = {cols, 1'b0};
        prod = 64'(x) * 64'(DIV_RECIP);
        marg = prod[DIV_SH +: COLS_W];
        w    = cols - {marg[COLS_W-2:0], 1'b0};
        if (w == '0) begin
            w = COLS_W'(1);
        end
        return w;
    endfunction

endpackage

`default_nettype wire

[src/greedy_word_wrap_breaker.sv]
// Top level of the greedy word-wrap line breaker.
// Path: an accepted request is written into the queue, then loaded into the output register on m_.
// Throughput: one input item per cycle while the queue is not full; an item giving two lines
// leaves the single output register one line at a time, with a four-request queue absorbing the bursts.
// Reset (aresetn low, synchronous): line state, queue and counters clear, wrap width returns to that of 80 columns.
`default_nettype none

module greedy_word_wrap_breaker import gwwb_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wen,
    input  wire logic [COLS_W-1:0]     cfg_wdata,   // screen_columns
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [CH_W-1:0]       s_tdata,     // ch
    input  wire logic                  s_tlast,     // line_end
    input  wire logic                  s_tuser,     // has_char
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_DATA_W-1:0]      m_tdata,     // display_index, line_offset, line_length
    output logic                       m_tlast,     // ends_source_line
    output logic [1:0]                 m_tuser      // last_in_item, too_long
);

    gwwb_entry_t push_data;
    gwwb_entry_t head;
    gwwb_qstat_t stat;
    logic        push;
    logic        pop;
    logic        accept;

    assign s_tready = !stat.full;
    assign accept   = s_tvalid && s_tready;

    gwwb_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .accept    (accept),
        .ch        (s_tdata),
        .has_char  (s_tuser),
        .line_end  (s_tlast),
        .push      (push),
        .push_data (push_data)
    );

    gwwb_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .stat      (stat)
    );

    gwwb_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .stat     (stat),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

[src/gwwb_front.sv]
// Front end: accepts characters, tracks break points and builds display line requests.
`default_nettype none

module gwwb_front import gwwb_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_wen,
    input  wire logic [COLS_W-1:0] cfg_wdata,
    input  wire logic              accept,
    input  wire logic [CH_W-1:0]   ch,
    input  wire logic              has_char,
    input  wire logic              line_end,
    output logic                   push,
    output gwwb_entry_t            push_data
);

    logic [COLS_W-1:0] wrap_reg;
    logic [POS_W-1:0]  ls_reg, ls_next;
    logic [POS_W-1:0]  cp_reg, cp_next;
    logic [POS_W-1:0]  bp_reg, bp_next;
    logic              bv_reg, bv_next;
    logic              bh_reg, bh_next;
    logic              ov_reg, ov_next;

    logic              brk;
    logic [OFF_W-1:0]  brk_off;
    logic [LEN_W-1:0]  brk_len;
    logic              tail_chars;
    logic [LEN_W-1:0]  tail_len;
    logic [OFF_W-1:0]  tail_off;
    logic              ov_char;

    always_comb begin
        ls_next    = ls_reg;
        cp_next    = cp_reg;
        bp_next    = bp_reg;
        bv_next    = bv_reg;
        bh_next    = bh_reg;
        ov_next    = ov_reg;
        brk        = 1'b0;
        brk_off    = OFF_W'(ls_reg);
        brk_len    = '0;

        if (has_char) begin
            if (cp_reg == POS_MAX) begin
                // drop the character, flag the line as too long
                ov_next = 1'b1;
            end else begin
                cp_next = cp_reg + POS_W'(1);
                if ((ch == CH_SPACE || ch == CH_HYPHEN) && cp_reg > ls_reg) begin
                    bp_next = cp_reg;
                    bv_next = 1'b1;
                    bh_next = (ch == CH_HYPHEN);
                end
                if (CMP_W'(cp_reg - ls_reg) >= CMP_W'(wrap_reg)) begin
                    brk = 1'b1;
                    if (bv_next) begin
                        brk_len = LEN_W'(bp_next - ls_reg + POS_W'(bh_next));
                        ls_next = bp_next + POS_W'(1);
                    end else begin
                        brk_len = LEN_W'(cp_reg - ls_reg);
                        ls_next = cp_reg;
                    end
                    bv_next = 1'b0;
                    bh_next = 1'b0;
                end
            end
        end

        ov_char    = ov_next;
        tail_chars = cp_next > ls_next;
        tail_off   = OFF_W'(ls_next);
        tail_len   = tail_chars ? LEN_W'(cp_next - ls_next) : '0;

        if (line_end) begin
            ls_next = '0;
            cp_next = '0;
            bp_next = '0;
            bv_next = 1'b0;
            bh_next = 1'b0;
            ov_next = 1'b0;
        end
    end

    always_comb begin
        push_data.too_long = ov_char;
        push_data.b_off    = tail_off;
        push_data.b_len    = tail_len;
        if (brk) begin
            push_data.two   = line_end && tail_chars;
            push_data.a_off = brk_off;
            push_data.a_len = brk_len;
            push_data.a_end = line_end && !tail_chars;
        end else begin
            push_data.two   = 1'b0;
            push_data.a_off = tail_off;
            push_data.a_len = tail_len;
            push_data.a_end = 1'b1;
        end
        push = accept && (brk || line_end);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wrap_reg <= wrap_width_f(COLS_RESET);
            ls_reg   <= '0;
            cp_reg   <= '0;
            bp_reg   <= '0;
            bv_reg   <= 1'b0;
            bh_reg   <= 1'b0;
            ov_reg   <= 1'b0;
        end else begin
            if (cfg_wen) begin
                wrap_reg <= wrap_width_f(cfg_wdata);
            end
            if (accept) begin
                ls_reg <= ls_next;
                cp_reg <= cp_next;
                bp_reg <= bp_next;
                bv_reg <= bv_next;
                bh_reg <= bh_next;
                ov_reg <= ov_next;
            end
        end
    end

endmodule

`default_nettype wire

[src/gwwb_queue.sv]
// Short request queue between the front end and the output stage.
`default_nettype none

module gwwb_queue import gwwb_pkg::*; (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         push,
    input  wire gwwb_entry_t  push_data,
    input  wire logic         pop,
    output gwwb_entry_t       head,
    output gwwb_qstat_t       stat
);

    gwwb_entry_t          store [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg;
    logic [Q_PTR_W-1:0]   rd_ptr_reg;
    logic [Q_PTR_W:0]     count_reg, count_next;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + (Q_PTR_W + 1)'(1);
        end else if (pop && !push) begin
            count_next = count_reg - (Q_PTR_W + 1)'(1);
        end
        stat.full  = (count_reg == (Q_PTR_W + 1)'(Q_DEPTH));
        stat.empty = (count_reg == '0);
        head       = store[rd_ptr_reg];
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            store[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + Q_PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + Q_PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

[src/gwwb_back.sv]
// Back end: splits queued requests into display lines, numbers them, holds the output register.
`default_nettype none

module gwwb_back import gwwb_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire gwwb_entry_t           head,
    input  wire gwwb_qstat_t           stat,
    output logic                       pop,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_DATA_W-1:0]      m_tdata,
    output logic                       m_tlast,
    output logic [1:0]                 m_tuser
);

    logic              phase_reg;
    logic [IDX_W-1:0]  cnt_reg;
    logic              valid_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [OFF_W-1:0]  off_reg;
    logic [LEN_W-1:0]  len_reg;
    logic              end_reg;
    logic              last_reg;
    logic              long_reg;

    logic              load;
    logic              first_of_two;

    assign first_of_two = head.two && !phase_reg;
    assign load         = !stat.empty && (!valid_reg || m_tready);
    assign pop          = load && !first_of_two;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= 1'b0;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            if (load) begin
                valid_reg <= 1'b1;
                phase_reg <= first_of_two;
                if (cnt_reg != IDX_MAX) begin
                    cnt_reg <= cnt_reg + IDX_W'(1);
                end
            end else if (m_tready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            idx_reg  <= cnt_reg;
            long_reg <= head.too_long;
            last_reg <= !first_of_two;
            if (phase_reg) begin
                off_reg <= head.b_off;
                len_reg <= head.b_len;
                end_reg <= 1'b1;
            end else begin
                off_reg <= head.a_off;
                len_reg <= head.a_len;
                end_reg <= head.a_end;
            end
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = OUT_DATA_W'({len_reg, off_reg, idx_reg});
    assign m_tlast  = end_reg;
    assign m_tuser  = {long_reg, last_reg};

endmodule

`default_nettype wire
